FILE: sv/gds_pkg.sv
package gds_pkg;

   localparam int YEAR_W  = 14;
   localparam int MONTH_W = 4;
   localparam int DAY_W   = 5;
   localparam int STEP_W  = 10;
   localparam int CMD_W   = 2;
   localparam int STAT_W  = 2;

   localparam int MAX_YEAR = 9999;
   localparam int MAX_STEP = 1023;

   localparam logic [YEAR_W-1:0]  YEAR_MAX   = YEAR_W'(MAX_YEAR);
   localparam logic [YEAR_W-1:0]  YEAR_RESET = YEAR_W'(1900);
   localparam logic [STEP_W-1:0]  STEP_CAP   =
      (MAX_STEP > (2 ** STEP_W) - 1) ? {STEP_W{1'b1}} : STEP_W'(MAX_STEP);

   localparam logic [MONTH_W-1:0] JAN = MONTH_W'(1);
   localparam logic [MONTH_W-1:0] FEB = MONTH_W'(2);
   localparam logic [MONTH_W-1:0] DEC = MONTH_W'(12);
   localparam logic [DAY_W-1:0]   DAY_FIRST = DAY_W'(1);
   localparam logic [DAY_W-1:0]   DAY_LAST  = DAY_W'(31);

   // y / 100 as (y * 5243) >> 19, exact for all 14-bit y
   localparam int DIV100_SHIFT = 19;
   localparam logic [12:0] DIV100_MUL = 13'd5243;

   typedef enum logic [CMD_W-1:0] {
      CMD_SET = 2'd0,
      CMD_FWD = 2'd1,
      CMD_BWD = 2'd2
   } gds_cmd_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK     = 2'd0,
      STAT_REJECT = 2'd1,
      STAT_FLOOR  = 2'd2,
      STAT_CEIL   = 2'd3
   } gds_status_type;

   typedef struct packed {
      logic [YEAR_W-1:0]  year;
      logic [MONTH_W-1:0] month;
      logic [DAY_W-1:0]   day;
   } gds_date_type;

   typedef struct packed {
      logic load_set;
      logic advance;
      logic backward;
      logic emit;
   } gds_ctl_type;

   function automatic logic gds_is_leap(input logic [YEAR_W-1:0] y);
      logic [YEAR_W+12:0] prod;
      logic [7:0]         cent;
      logic [YEAR_W-1:0]  rem;
      prod = (YEAR_W+13)'(y) * (YEAR_W+13)'(DIV100_MUL);
      cent = 8'(prod >> DIV100_SHIFT);
      rem  = y - YEAR_W'(YEAR_W'(cent) * YEAR_W'(100));
      return (y[1:0] == 2'd0) && ((rem != '0) || (cent[1:0] == 2'd0));
   endfunction

   function automatic logic [DAY_W-1:0] gds_days_in(input logic [MONTH_W-1:0] m,
                                                    input logic [YEAR_W-1:0] y);
      logic [DAY_W-1:0] len;
      case (m) inside
         FEB:                    len = gds_is_leap(y) ? DAY_W'(29) : DAY_W'(28);
         4'd4, 4'd6, 4'd9, 4'd11: len = DAY_W'(30);
         default:                len = DAY_LAST;
      endcase
      return len;
   endfunction

endpackage

FILE: sv/gds_day_unit.sv
module gds_day_unit
   import gds_pkg::*;
(
   input  gds_date_type      cur,
   input  logic [YEAR_W-1:0] min_year,
   input  logic              backward,
   output gds_date_type      nxt,
   output logic              blocked
);

   logic [DAY_W-1:0]   dim;
   logic [MONTH_W-1:0] prev_month;

   assign dim        = gds_days_in(cur.month, cur.year);
   assign prev_month = cur.month - MONTH_W'(1);

   always_comb begin
      nxt = cur;
      if (backward) begin
         blocked = (cur.year < min_year) ||
                   ((cur.year == min_year) && (cur.month == JAN) && (cur.day == DAY_FIRST));
         if (cur.day > DAY_FIRST) begin
            nxt.day = cur.day - DAY_W'(1);
         end else if (cur.month <= JAN) begin
            nxt.day   = DAY_LAST;
            nxt.month = DEC;
            nxt.year  = cur.year - YEAR_W'(1);
         end else begin
            nxt.month = prev_month;
            nxt.day   = gds_days_in(prev_month, cur.year);
         end
      end else begin
         blocked = (cur.year > YEAR_MAX) ||
                   ((cur.year == YEAR_MAX) && (cur.month == DEC) && (cur.day == DAY_LAST));
         if (cur.day < dim) begin
            nxt.day = cur.day + DAY_W'(1);
         end else if (cur.month >= DEC) begin
            nxt.day   = DAY_FIRST;
            nxt.month = JAN;
            nxt.year  = cur.year + YEAR_W'(1);
         end else begin
            nxt.day   = DAY_FIRST;
            nxt.month = cur.month + MONTH_W'(1);
         end
      end
   end

endmodule

FILE: sv/gds_ctrl.sv
module gds_ctrl
   import gds_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [CMD_W-1:0]  cmd,
   input  gds_date_type      set_date,
   input  logic [STEP_W-1:0] step_count,
   input  logic [YEAR_W-1:0] min_year,
   input  logic              blocked,
   input  logic              rsp_free,
   output gds_ctl_type       ctl,
   output gds_status_type    status
);

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_RUN  = 2'b10
   } gds_state_type;

   gds_state_type     state_ff, state_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic              back_ff, back_in;
   gds_status_type    status_ff, status_in;
   logic              accept;
   logic              set_ok;
   logic [STEP_W-1:0] cnt_capped;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign cnt_capped = (step_count > STEP_CAP) ? STEP_CAP : step_count;

   assign set_ok = (set_date.month >= JAN) && (set_date.month <= DEC) &&
                   (set_date.day >= DAY_FIRST) &&
                   (set_date.day <= gds_days_in(set_date.month, set_date.year)) &&
                   (set_date.year >= min_year) && (set_date.year <= YEAR_MAX);

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      back_in      = back_ff;
      status_in    = status_ff;
      ctl          = '0;
      ctl.backward = back_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in  = S_RUN;
               cnt_in    = '0;
               status_in = STAT_OK;
               unique case (cmd)
                  CMD_SET: begin
                     ctl.load_set = set_ok;
                     status_in    = set_ok ? STAT_OK : STAT_REJECT;
                  end
                  CMD_FWD: begin
                     cnt_in  = cnt_capped;
                     back_in = 1'b0;
                  end
                  CMD_BWD: begin
                     cnt_in  = cnt_capped;
                     back_in = 1'b1;
                  end
                  default: status_in = STAT_REJECT;
               endcase
            end
         end
         S_RUN: begin
            if (cnt_ff != '0) begin
               if (blocked) begin
                  // date sits at a limit; the rest of the count is dropped
                  status_in = back_ff ? STAT_FLOOR : STAT_CEIL;
                  cnt_in    = '0;
               end else begin
                  ctl.advance = 1'b1;
                  cnt_in      = cnt_ff - STEP_W'(1);
               end
            end else if (rsp_free) begin
               ctl.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         cnt_ff    <= '0;
         back_ff   <= 1'b0;
         status_ff <= STAT_OK;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         back_ff   <= back_in;
         status_ff <= status_in;
      end
   end

   assign status = status_ff;

endmodule

FILE: sv/gregorian_date_stepper.sv
// A set or an unknown command is taken while idle; its result beat is then
// registered once the output register is free. A step first moves the date by
// the days actually taken (count capped), one day a cycle; a run stopped at a
// date limit first records its limit status. A new request is taken only after
// the last result has gone to the output register.
// Reset (synchronous): date 1 Jan 1900, min_year 1900, no result pending.
module gregorian_date_stepper
   import gds_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // set_day[4:0], set_month[8:5], set_year[22:9], step_count[32:23]
   input  logic [39:0]           req_tdata,
   // command[1:0]
   input  logic [CMD_W-1:0]      req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // day[4:0], month[8:5], year[22:9], status[24:23]
   output logic [31:0]           rsp_tdata,
   input  logic                  csr_wr_en,
   input  logic [YEAR_W-1:0]     csr_wr_data
);

   gds_date_type      date_ff, date_in;
   gds_date_type      date_next;
   gds_date_type      set_date;
   logic [YEAR_W-1:0] min_year_ff, min_year_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [31:0]       rsp_data_ff, rsp_data_in;
   logic [STEP_W-1:0] step_count;
   logic              blocked;
   logic              rsp_free;
   gds_ctl_type       ctl;
   gds_status_type    status;

   // year[22:9], month[8:5], day[4:0] line up with the packed date
   assign set_date   = gds_date_type'(req_tdata[22:0]);
   assign step_count = req_tdata[32:23];

   assign rsp_free = !rsp_valid_ff || rsp_tready;

   gds_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .cmd        (req_tuser),
      .set_date   (set_date),
      .step_count (step_count),
      .min_year   (min_year_ff),
      .blocked    (blocked),
      .rsp_free   (rsp_free),
      .ctl        (ctl),
      .status     (status)
   );

   gds_day_unit u_day (
      .cur      (date_ff),
      .min_year (min_year_ff),
      .backward (ctl.backward),
      .nxt      (date_next),
      .blocked  (blocked)
   );

   always_comb begin
      date_in = date_ff;
      if (ctl.load_set) begin
         date_in = set_date;
      end else if (ctl.advance) begin
         date_in = date_next;
      end
   end

   assign min_year_in = csr_wr_en ? csr_wr_data : min_year_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (ctl.emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {7'd0, status, date_ff.year, date_ff.month, date_ff.day};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         date_ff      <= '{year: YEAR_RESET, month: JAN, day: DAY_FIRST};
         min_year_ff  <= YEAR_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         date_ff      <= date_in;
         min_year_ff  <= min_year_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

FILE: sv/gds_checker.sv
module gds_checker
   import gds_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_tvalid,
   input logic              req_tready,
   input logic              rsp_tvalid,
   input logic              rsp_tready,
   input logic [31:0]       rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result beat changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("block not empty after reset");

   a_busy_after_beat: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second beat taken while an item is in work");

   a_date_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[4:0] != 5'd0) && (rsp_tdata[8:5] != 4'd0) &&
                     (rsp_tdata[8:5] <= 4'd12) && (rsp_tdata[31:25] == 7'd0))
      else $error("result date out of range");

endmodule

bind gregorian_date_stepper gds_checker u_gds_checker (.*);

FILE: test/tb.sv
module tb;
   import gds_pkg::*;

   localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
   localparam int STALL_LIMIT = 4000;

   typedef struct packed {
      logic [CMD_W-1:0]   cmd;
      logic [DAY_W-1:0]   day;
      logic [MONTH_W-1:0] month;
      logic [YEAR_W-1:0]  year;
      logic [STEP_W-1:0]  count;
   } date_cmd_type;

   typedef struct packed {
      logic [DAY_W-1:0]   day;
      logic [MONTH_W-1:0] month;
      logic [YEAR_W-1:0]  year;
      gds_status_type     status;
   } date_beat_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [39:0]       req_tdata = '0;
   logic [CMD_W-1:0]  req_tuser = '0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [31:0]       rsp_tdata;
   logic              csr_wr_en = 1'b0;
   logic [YEAR_W-1:0] csr_wr_data = '0;

   date_cmd_type  pending_cmds[$];
   date_beat_type due_dates[$];
   date_cmd_type  req_item;
   date_beat_type want;
   int         req_hold = 0;
   int         rsp_hold = 0;
   int         rsp_beats = 0;
   int         errors = 0;
   int         stuck_cycles = 0;
   bit         quiet_mode = 1'b0;

   // calendar state tracked alongside the block
   int cal_day    = int'(DAY_FIRST);
   int cal_month  = int'(JAN);
   int cal_year   = int'(YEAR_RESET);
   int floor_year = int'(YEAR_RESET);

   gregorian_date_stepper dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #6 clock = ~clock;

   function automatic bit leap_year(int y);
      return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
   endfunction

   function automatic int month_days(int m, int y);
      if (m == int'(FEB)) begin
         return leap_year(y) ? 29 : 28;
      end
      if (m == 4 || m == 6 || m == 9 || m == 11) begin
         return 30;
      end
      return 31;
   endfunction

   function bit day_forward();
      if (cal_year > MAX_YEAR ||
          (cal_year == MAX_YEAR && cal_month == int'(DEC) && cal_day == int'(DAY_LAST))) begin
         return 1'b0;
      end
      if (cal_day < month_days(cal_month, cal_year)) begin
         cal_day = cal_day + 1;
      end else if (cal_month >= int'(DEC)) begin
         cal_day   = int'(DAY_FIRST);
         cal_month = int'(JAN);
         cal_year  = cal_year + 1;
      end else begin
         cal_day   = int'(DAY_FIRST);
         cal_month = cal_month + 1;
      end
      return 1'b1;
   endfunction

   function bit day_backward();
      if (cal_year < floor_year ||
          (cal_year == floor_year && cal_month == int'(JAN) && cal_day == int'(DAY_FIRST))) begin
         return 1'b0;
      end
      if (cal_day > int'(DAY_FIRST)) begin
         cal_day = cal_day - 1;
      end else if (cal_month <= int'(JAN)) begin
         cal_day   = int'(DAY_LAST);
         cal_month = int'(DEC);
         cal_year  = cal_year - 1;
      end else begin
         cal_month = cal_month - 1;
         cal_day   = month_days(cal_month, cal_year);
      end
      return 1'b1;
   endfunction

   function date_beat_type apply_command(input date_cmd_type c);
      date_beat_type  r;
      gds_status_type st;
      int             n;
      int             k;
      int             sd;
      int             sm;
      int             sy;
      st = STAT_OK;
      sd = int'(c.day);
      sm = int'(c.month);
      sy = int'(c.year);
      n  = (int'(c.count) > int'(STEP_CAP)) ? int'(STEP_CAP) : int'(c.count);
      case (c.cmd)
         CMD_SET: begin
            if (sm >= int'(JAN) && sm <= int'(DEC) && sd >= int'(DAY_FIRST) &&
                sd <= month_days(sm, sy) && sy >= floor_year && sy <= MAX_YEAR) begin
               cal_day   = sd;
               cal_month = sm;
               cal_year  = sy;
            end else begin
               st = STAT_REJECT;
            end
         end
         CMD_FWD: begin
            for (k = 0; k < n; k++) begin
               if (!day_forward()) begin
                  st = STAT_CEIL;
               end
            end
         end
         CMD_BWD: begin
            for (k = 0; k < n; k++) begin
               if (!day_backward()) begin
                  st = STAT_FLOOR;
               end
            end
         end
         default: st = STAT_REJECT;
      endcase
      r.day    = DAY_W'(cal_day);
      r.month  = MONTH_W'(cal_month);
      r.year   = YEAR_W'(cal_year);
      r.status = st;
      return r;
   endfunction

   function automatic date_cmd_type cmd_item(logic [CMD_W-1:0] op, int d, int m, int y, int n);
      date_cmd_type c;
      c.cmd   = op;
      c.day   = DAY_W'(d);
      c.month = MONTH_W'(m);
      c.year  = YEAR_W'(y);
      c.count = STEP_W'(n);
      return c;
   endfunction

   function automatic int pick_pause();
      int r;
      r = int'($urandom_range(0, 99));
      if (quiet_mode || r < 55) begin
         return 0;
      end
      if (r < 92) begin
         return int'($urandom_range(1, 3));
      end
      return int'($urandom_range(10, 40));
   endfunction

   // sets (mostly valid, near or between the year limits), steps that walk across them, and spare commands
   function automatic date_cmd_type random_command(int low_year);
      date_cmd_type c;
      int r;
      int y;
      int m;
      c.cmd   = CMD_SET;
      c.day   = DAY_W'($urandom);
      c.month = MONTH_W'($urandom);
      c.year  = YEAR_W'($urandom);
      c.count = STEP_W'($urandom);
      r = int'($urandom_range(0, 99));
      if (r < 42) begin
         if (r < 36 && low_year <= MAX_YEAR) begin
            case ($urandom_range(0, 3))
               0:       y = low_year + int'($urandom_range(0, 2));
               1:       y = MAX_YEAR - int'($urandom_range(0, 2));
               default: y = int'($urandom_range(low_year, MAX_YEAR));
            endcase
            if (y > MAX_YEAR) begin
               y = MAX_YEAR;
            end
            if (y < low_year) begin
               y = low_year;
            end
            m = int'($urandom_range(1, 12));
            c.month = MONTH_W'(m);
            c.year  = YEAR_W'(y);
            c.day   = DAY_W'($urandom_range(1, month_days(m, y)));
         end
      end else if (r < 95) begin
         c.cmd = (r < 68) ? CMD_FWD : CMD_BWD;
         case ($urandom_range(0, 99)) inside
            [0:64]:  c.count = STEP_W'($urandom_range(0, 30));
            [65:87]: c.count = STEP_W'($urandom_range(0, 300));
            [88:96]: c.count = STEP_W'($urandom_range(0, 1023));
            default: c.count = STEP_CAP;
         endcase
      end else begin
         c.cmd = CMD_SPARE;
      end
      return c;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int exp);
      $display("MISMATCH beat %0d %s: got %0d, expected %0d", rsp_beats, what, got, exp);
      errors++;
   endtask

   task automatic wait_drained();
      do begin
         @(negedge clock);
      end while (pending_cmds.size() != 0 || req_tvalid || due_dates.size() != 0);
   endtask

   task automatic run_phase(input int low_year, input int items, input bit quiet);
      wait_drained();
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= YEAR_W'(low_year);
      @(posedge clock);
      floor_year = low_year;
      csr_wr_en <= 1'b0;
      @(negedge clock);
      quiet_mode = quiet;
      repeat (items) pending_cmds.push_back(random_command(low_year));
   endtask

   // input beats
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_hold = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            due_dates.push_back(apply_command(req_item));
         end
         if (!req_tvalid || req_tready) begin
            if (req_hold > 0) begin
               req_hold = req_hold - 1;
               req_tvalid <= 1'b0;
            end else if (pending_cmds.size() != 0) begin
               req_item = pending_cmds.pop_front();
               req_tdata <= {7'd0, req_item.count, req_item.year, req_item.month, req_item.day};
               req_tuser <= req_item.cmd;
               req_tvalid <= 1'b1;
               req_hold = pick_pause();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // result beats
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_hold = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (due_dates.size() == 0) begin
               report_mismatch("unexpected beat", int'(rsp_tdata), 0);
            end else begin
               want = due_dates.pop_front();
               if (rsp_tdata[4:0] != want.day) begin
                  report_mismatch("day", int'(rsp_tdata[4:0]), int'(want.day));
               end
               if (rsp_tdata[8:5] != want.month) begin
                  report_mismatch("month", int'(rsp_tdata[8:5]), int'(want.month));
               end
               if (rsp_tdata[22:9] != want.year) begin
                  report_mismatch("year", int'(rsp_tdata[22:9]), int'(want.year));
               end
               if (rsp_tdata[24:23] != want.status) begin
                  report_mismatch("status", int'(rsp_tdata[24:23]), int'(want.status));
               end
            end
            rsp_beats++;
         end
         if (rsp_hold > 0) begin
            rsp_hold = rsp_hold - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if ($urandom_range(0, 3) == 0) begin
               rsp_hold = pick_pause();
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_wr_en) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= STALL_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      pending_cmds.push_back(cmd_item(CMD_SET, 29, 2, 2000, 0));
      pending_cmds.push_back(cmd_item(CMD_SET, 29, 2, 1900, 0));
      pending_cmds.push_back(cmd_item(CMD_SET, 29, 2, 2024, 0));
      pending_cmds.push_back(cmd_item(CMD_SET, 31, 4, 2024, 0));
      pending_cmds.push_back(cmd_item(CMD_SET, 0, 1, 2000, 0));
      pending_cmds.push_back(cmd_item(CMD_SET, 1, 0, 2000, 0));
      pending_cmds.push_back(cmd_item(CMD_SET, 31, 15, 2000, 0));
      pending_cmds.push_back(cmd_item(CMD_SET, 1, 1, 1899, 0));
      pending_cmds.push_back(cmd_item(CMD_SET, 1, 1, 10000, 0));
      pending_cmds.push_back(cmd_item(CMD_SET, 31, 12, 16383, 1023));
      pending_cmds.push_back(cmd_item(CMD_SET, 28, 2, 2100, 0));
      pending_cmds.push_back(cmd_item(CMD_FWD, 0, 0, 0, 1));
      pending_cmds.push_back(cmd_item(CMD_BWD, 0, 0, 0, 1));
      pending_cmds.push_back(cmd_item(CMD_SET, 1, 3, 2000, 0));
      pending_cmds.push_back(cmd_item(CMD_BWD, 31, 15, 16383, 1));
      pending_cmds.push_back(cmd_item(CMD_SET, 31, 12, 9999, 0));
      pending_cmds.push_back(cmd_item(CMD_FWD, 0, 0, 0, 1));
      pending_cmds.push_back(cmd_item(CMD_FWD, 0, 0, 0, 0));
      pending_cmds.push_back(cmd_item(CMD_SET, 26, 12, 9999, 0));
      pending_cmds.push_back(cmd_item(CMD_FWD, 0, 0, 0, 1023));
      pending_cmds.push_back(cmd_item(CMD_SET, 3, 1, 1900, 0));
      pending_cmds.push_back(cmd_item(CMD_BWD, 0, 0, 0, 5));
      pending_cmds.push_back(cmd_item(CMD_SPARE, 31, 15, 16383, 1023));
      pending_cmds.push_back(cmd_item(CMD_SET, 31, 12, 1999, 0));
      pending_cmds.push_back(cmd_item(CMD_FWD, 0, 0, 0, 1023));
      pending_cmds.push_back(cmd_item(CMD_BWD, 0, 0, 0, 1023));
      run_phase(int'(YEAR_RESET), 100, 1'b0);
      run_phase(0, 100, 1'b1);
      run_phase(MAX_YEAR, 80, 1'b0);
      run_phase(16383, 60, 1'b0);
      run_phase(int'($urandom_range(1, 9998)), 100, 1'b0);
      run_phase(2000, 120, 1'b0);
      wait_drained();
      repeat (8) @(posedge clock);
      if (errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
